// ----- design/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and default sizes of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

	// default sizes
	localparam int DEF_MAX_SLOTS = 256;
	localparam int DEF_WORD_BITS = 64;

	// field widths
	localparam int SLOT_W  = 8;
	localparam int LIMIT_W = 9;
	localparam int STAT_W  = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	// request codes
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_id;
		logic [STAT_W-1:0] status;
	} rsp_t;

endpackage

// ----- design/bsa_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/bitmap_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Used-slot bitmap allocator: allocate finds and sets the lowest clear bit
// below the slot limit, release clears the bit of a given slot.
// ----------------------------------------------------------------------------
// The bitmap sits in one RAM of WORD_BITS-wide words with a registered read.
// After reset a clearing pass writes every map word to zero, one word a cycle;
// no request is taken during it, though slot_limit writes are. A request is
// taken only while the block is idle. An allocate scans the map words in
// order from word zero until it finds a clear bit, at most
// ceil(limit/WORD_BITS) words; the scan reads and tests one word per cycle
// through the single RAM read port. A release reads, modifies and writes back
// one map word. An out of range release, or an allocate with a limit of zero,
// gives its status without a RAM access. The result sits in an output
// register, so a stalled result only holds the next request back once that
// one is done.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top
	import bsa_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_data
);

	localparam int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int BASE_W    = LIMIT_W + 1 + ((BW > LIMIT_W) ? BW - LIMIT_W : 0);
	// reciprocal for slot / WORD_BITS on an 8-bit slot
	localparam int RECIP     = (1 << 16) / WORD_BITS + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_REL,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        word_q;
	logic [BASE_W-1:0]    base_q;
	logic [BW-1:0]        bitpos_q;
	logic [LIMIT_W-1:0]   slot_limit_q;
	rsp_t                 res_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// ram ports
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;

	logic                 accept;
	logic                 out_free;
	logic [LIMIT_W-1:0]   lim_eff;
	logic [BASE_W-1:0]    lim_ext;
	logic [BASE_W-1:0]    remaining;
	logic [BASE_W-1:0]    next_base;
	logic [24:0]          recip_prod;
	logic [SLOT_W-1:0]    rel_word;
	logic [15:0]          rel_word_base;
	logic [BW-1:0]        rel_bit;
	logic                 rel_in_range;
	logic [WORD_BITS-1:0] free_bits;
	logic                 found;
	logic [BW-1:0]        found_pos;
	logic [BASE_W-1:0]    found_slot;

	bsa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// handshake
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// limit clipped to the map capacity
	assign lim_eff = (int'(slot_limit_q) > MAX_SLOTS) ? LIMIT_W'(MAX_SLOTS) : slot_limit_q;
	assign lim_ext = BASE_W'(lim_eff);

	// release slot split into word and bit by reciprocal multiply
	assign recip_prod    = 25'(req.slot_index) * 25'(RECIP);
	assign rel_word      = recip_prod[23:16];
	assign rel_word_base = 16'(rel_word) * 16'(WORD_BITS);
	assign rel_bit       = BW'(16'(req.slot_index) - rel_word_base);
	assign rel_in_range  = BASE_W'(req.slot_index) < lim_ext;

	// first clear bit of the current word among slots below the limit
	assign remaining = lim_ext - base_q;
	assign next_base = base_q + BASE_W'(WORD_BITS);

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			free_bits[j] = !rd_data[j] && (BASE_W'(j) < remaining);
		end
	end

	always_comb begin
		found_pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				found_pos = BW'(j);
			end
		end
	end

	assign found      = |free_bits;
	assign found_slot = base_q + BASE_W'(found_pos);

	// ram control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = word_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE: begin
				if (accept && req.req_type == REQ_ALLOC) begin
					rd_en   = (lim_eff != '0);
					rd_addr = '0;
				end else if (accept) begin
					rd_en   = rel_in_range;
					rd_addr = AW'(rel_word);
				end
			end
			S_SCAN: begin
				if (found) begin
					wr_en   = 1'b1;
					wr_data = rd_data | (WORD_BITS'(1) << found_pos);
				end else begin
					rd_en   = (next_base < lim_ext);
					rd_addr = word_q + AW'(1);
				end
			end
			S_REL: begin
				wr_en   = 1'b1;
				wr_data = rd_data & ~(WORD_BITS'(1) << bitpos_q);
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer, limit register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			word_q       <= '0;
			base_q       <= '0;
			bitpos_q     <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			slot_limit_q <= LIMIT_RESET;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				slot_limit_q <= cfg_data;
			end

			// result word register: load a finished result, drop a taken one
			if (state_q == S_OUT && out_free) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						word_q   <= '0;
						base_q   <= '0;
						bitpos_q <= rel_bit;
						if (req.req_type == REQ_ALLOC) begin
							if (lim_eff == '0) begin
								res_q   <= '{slot_id: '0, status: ST_FULL};
								state_q <= S_OUT;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							if (rel_in_range) begin
								word_q  <= AW'(rel_word);
								state_q <= S_REL;
							end else begin
								res_q   <= '{slot_id: '0, status: ST_RANGE};
								state_q <= S_OUT;
							end
						end
					end
				end
				S_SCAN: begin
					if (found) begin
						res_q   <= '{slot_id: SLOT_W'(found_slot), status: ST_OK};
						state_q <= S_OUT;
					end else if (next_base < lim_ext) begin
						word_q <= word_q + AW'(1);
						base_q <= next_base;
					end else begin
						res_q   <= '{slot_id: '0, status: ST_FULL};
						state_q <= S_OUT;
					end
				end
				S_REL: begin
					res_q   <= '{slot_id: '0, status: ST_OK};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
